// ===== rtl/core/pcog_pkg.sv =====
// Shared constants, types and codes for the occupancy grid block.
`default_nettype none

package pcog_pkg;

    // Map geometry
    localparam int MAP_WIDTH  = 400;
    localparam int MAP_HEIGHT = 400;
    localparam int GRID_CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int GRID_WORDS = (GRID_CELLS + 63) / 64;
    localparam int WORD_AW    = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
    localparam int CIDX_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int COL_W      = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int ROW_W      = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int QUOT_W   = COORD_W;
    localparam int CNT_W    = $clog2(QUOT_W);
    localparam int CS_W     = 10;
    localparam int WIDX_W   = 12;
    localparam int STAT_W   = 2;
    localparam int CELL_W   = 18;
    localparam int DATA_W   = 64;
    localparam int BIT_W    = 6;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = PADDR_W - 2;

    // Register reset values
    localparam logic signed [COORD_W-1:0] RST_Z_MIN    = 16'sd100;
    localparam logic signed [COORD_W-1:0] RST_Z_MAX    = 16'sd1500;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_X = -16'sd10000;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_Y = -16'sd10000;
    localparam logic [CS_W-1:0]           RST_CELL_SZ  = 10'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_POINT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_MARKED   = 2'd0,
        STAT_FILTERED = 2'd1,
        STAT_OUTSIDE  = 2'd2,
        STAT_DONE     = 2'd3
    } status_t;

    typedef enum logic [REGIDX_W-1:0] {
        REG_Z_MIN     = 3'd0,
        REG_Z_MAX     = 3'd1,
        REG_ORIGIN_X  = 3'd2,
        REG_ORIGIN_Y  = 3'd3,
        REG_CELL_SIZE = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_MREAD,
        S_MMOD,
        S_RDATA,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] z_max;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [CS_W-1:0]           cell_size;
    } cfg_t;

    // One divider lane result: sign of the dividend and quotient magnitude
    typedef struct packed {
        logic              neg;
        logic [QUOT_W-1:0] quot;
    } div_lane_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcog_ram.sv =====
// Single-port synchronous RAM with registered read data.
`default_nettype none

module pcog_ram #(
    parameter int DEPTH = 2500,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcog_cfg.sv =====
// APB register file for height band, map origin and cell size.
`default_nettype none

module pcog_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcog_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pcog_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pcog_pkg::PDATA_W-1:0]  prdata,
    output pcog_pkg::cfg_t                     cfg
);

    logic signed [pcog_pkg::COORD_W-1:0] z_min_reg;
    logic signed [pcog_pkg::COORD_W-1:0] z_max_reg;
    logic signed [pcog_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [pcog_pkg::COORD_W-1:0] origin_y_reg;
    logic [pcog_pkg::CS_W-1:0]           cell_size_reg;
    pcog_pkg::reg_idx_t                  reg_idx;
    logic                                wr_en;

    assign reg_idx = pcog_pkg::reg_idx_t'(paddr[pcog_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_min_reg     <= pcog_pkg::RST_Z_MIN;
            z_max_reg     <= pcog_pkg::RST_Z_MAX;
            origin_x_reg  <= pcog_pkg::RST_ORIGIN_X;
            origin_y_reg  <= pcog_pkg::RST_ORIGIN_Y;
            cell_size_reg <= pcog_pkg::RST_CELL_SZ;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                pcog_pkg::REG_Z_MIN:     z_min_reg     <= pwdata[pcog_pkg::COORD_W-1:0];
                pcog_pkg::REG_Z_MAX:     z_max_reg     <= pwdata[pcog_pkg::COORD_W-1:0];
                pcog_pkg::REG_ORIGIN_X:  origin_x_reg  <= pwdata[pcog_pkg::COORD_W-1:0];
                pcog_pkg::REG_ORIGIN_Y:  origin_y_reg  <= pwdata[pcog_pkg::COORD_W-1:0];
                pcog_pkg::REG_CELL_SIZE: cell_size_reg <= pwdata[pcog_pkg::CS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            pcog_pkg::REG_Z_MIN:     prdata = pcog_pkg::PDATA_W'(unsigned'(z_min_reg));
            pcog_pkg::REG_Z_MAX:     prdata = pcog_pkg::PDATA_W'(unsigned'(z_max_reg));
            pcog_pkg::REG_ORIGIN_X:  prdata = pcog_pkg::PDATA_W'(unsigned'(origin_x_reg));
            pcog_pkg::REG_ORIGIN_Y:  prdata = pcog_pkg::PDATA_W'(unsigned'(origin_y_reg));
            pcog_pkg::REG_CELL_SIZE: prdata = pcog_pkg::PDATA_W'(cell_size_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.z_min     = z_min_reg;
    assign cfg.z_max     = z_max_reg;
    assign cfg.origin_x  = origin_x_reg;
    assign cfg.origin_y  = origin_y_reg;
    assign cfg.cell_size = cell_size_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcog_div.sv =====
// Two-lane restoring divider: signed dividend by unsigned cell size, one bit per cycle.
`default_nettype none

module pcog_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [pcog_pkg::DIFF_W-1:0]  dividend_x,
    input  wire logic signed [pcog_pkg::DIFF_W-1:0]  dividend_y,
    input  wire logic        [pcog_pkg::CS_W-1:0]    divisor,
    output logic                                     done,
    output pcog_pkg::div_lane_t                      res_x,
    output pcog_pkg::div_lane_t                      res_y
);

    localparam int NL = 2;

    logic signed [pcog_pkg::DIFF_W-1:0] dvd [NL];
    logic [pcog_pkg::QUOT_W-1:0]        mag_reg  [NL];
    logic [pcog_pkg::QUOT_W-1:0]        mag_next [NL];
    logic [pcog_pkg::CS_W-1:0]          rem_reg  [NL];
    logic [pcog_pkg::CS_W-1:0]          rem_next [NL];
    logic [pcog_pkg::QUOT_W-1:0]        abs_val  [NL];
    logic                               neg_reg  [NL];
    logic [pcog_pkg::CS_W:0]            shifted  [NL];
    logic                               ge       [NL];
    logic [pcog_pkg::CNT_W-1:0]         cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    assign dvd[0] = dividend_x;
    assign dvd[1] = dividend_y;

    // One restoring step per lane
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            abs_val[i] = dvd[i][pcog_pkg::DIFF_W-1] ? pcog_pkg::QUOT_W'(-dvd[i])
                                                      : pcog_pkg::QUOT_W'(dvd[i]);
            shifted[i] = {rem_reg[i], mag_reg[i][pcog_pkg::QUOT_W-1]};
            ge[i]      = (shifted[i] >= {1'b0, divisor});
            rem_next[i] = ge[i] ? pcog_pkg::CS_W'(shifted[i] - {1'b0, divisor})
                                : pcog_pkg::CS_W'(shifted[i]);
            mag_next[i] = {mag_reg[i][pcog_pkg::QUOT_W-2:0], ge[i]};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pcog_pkg::CNT_W'(pcog_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (start)
            begin
                mag_reg[i] <= abs_val[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= dvd[i][pcog_pkg::DIFF_W-1];
            end
            else if (busy_reg)
            begin
                mag_reg[i] <= mag_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign done       = done_reg;
    assign res_x.neg  = neg_reg[0];
    assign res_x.quot = mag_reg[0];
    assign res_y.neg  = neg_reg[1];
    assign res_y.quot = mag_reg[1];

endmodule

`default_nettype wire

// ===== rtl/core/point_cloud_occupancy_grid.sv =====
// Occupancy grid top level: command sequencer around the bitmap RAM.
//
// Usage: commands enter on the in_valid/in_ready channel (clear map, project a
// point, read one 64-cell word). Each accepted beat yields exactly one result
// beat on out_valid/out_ready carrying status, cell_index and occupancy_word.
// Configuration registers are written over the APB port while the block idles.
//
// One command is in flight at a time. Steps from accept to result valid:
//   project point: 16-step divider on both axes, then a read-modify-write
//                  of one bitmap word; both skipped if height filtered
//   read word:     one RAM read, skipped if the index is past the map
//   clear map:     all GRID_WORDS (2500) words, one RAM word zeroed per cycle
// in_ready rises together with out_valid, once the result is loaded into the
// output register; only then is the next command accepted.
// Reset: registers take their reset values and a clearing pass over all
// bitmap words zeroes the bitmap; in_ready stays low until it ends.
// Stall: a result waits in the output register; the next command is still
// accepted and computed, and its result waits until the register frees.
`default_nettype none

module point_cloud_occupancy_grid (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // command channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [pcog_pkg::CMD_W-1:0]    command,
    input  wire logic signed [pcog_pkg::COORD_W-1:0]  x_mm,
    input  wire logic signed [pcog_pkg::COORD_W-1:0]  y_mm,
    input  wire logic signed [pcog_pkg::COORD_W-1:0]  z_mm,
    input  wire logic        [pcog_pkg::WIDX_W-1:0]   word_index,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic             [pcog_pkg::STAT_W-1:0]   status,
    output logic             [pcog_pkg::CELL_W-1:0]   cell_index,
    output logic             [pcog_pkg::DATA_W-1:0]   occupancy_word,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [pcog_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [pcog_pkg::PDATA_W-1:0]  pwdata,
    output logic             [pcog_pkg::PDATA_W-1:0]  prdata,
    output logic                                      pready
);

    pcog_pkg::cfg_t                      cfg;
    pcog_pkg::fsm_t                      state_reg, state_next;
    logic [pcog_pkg::WORD_AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                                clr_cmd_reg, clr_cmd_next;
    pcog_pkg::status_t                   res_status_reg, res_status_next;
    logic [pcog_pkg::CIDX_W-1:0]         res_cell_reg, res_cell_next;
    logic [pcog_pkg::DATA_W-1:0]         res_word_reg, res_word_next;
    logic                                out_valid_reg;
    pcog_pkg::status_t                   out_status_reg;
    logic [pcog_pkg::CELL_W-1:0]         out_cell_reg;
    logic [pcog_pkg::DATA_W-1:0]         out_word_reg;
    logic                                out_load;

    logic                                accept;
    logic                                filtered;
    logic [pcog_pkg::CS_W-1:0]           cs_eff;
    logic signed [pcog_pkg::DIFF_W-1:0]  diff_x, diff_y;
    logic                                div_start, div_done;
    pcog_pkg::div_lane_t                 div_x, div_y;
    logic                                col_ok, row_ok;
    logic [pcog_pkg::COL_W-1:0]          col;
    logic [pcog_pkg::ROW_W-1:0]          row;
    logic [pcog_pkg::WORD_AW-1:0]        cell_word;
    logic [pcog_pkg::BIT_W-1:0]          cell_bit;

    logic                                ram_we;
    logic [pcog_pkg::WORD_AW-1:0]        ram_addr;
    logic [pcog_pkg::DATA_W-1:0]         ram_wdata, ram_rdata;

    // Configuration registers
    pcog_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Point front end: height band and origin offsets
    assign cs_eff   = (cfg.cell_size == '0) ? pcog_pkg::CS_W'(1) : cfg.cell_size;
    assign filtered = (z_mm < cfg.z_min) || (z_mm > cfg.z_max);
    assign diff_x   = {x_mm[pcog_pkg::COORD_W-1], x_mm}
                    - {cfg.origin_x[pcog_pkg::COORD_W-1], cfg.origin_x};
    assign diff_y   = {y_mm[pcog_pkg::COORD_W-1], y_mm}
                    - {cfg.origin_y[pcog_pkg::COORD_W-1], cfg.origin_y};

    pcog_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_x (diff_x),
        .dividend_y (diff_y),
        .divisor    (cs_eff),
        .done       (div_done),
        .res_x      (div_x),
        .res_y      (div_y)
    );

    // Truncation toward zero: a negative quotient of magnitude zero is cell 0
    assign col_ok = div_x.neg ? (div_x.quot == '0)
                              : (div_x.quot < pcog_pkg::QUOT_W'(pcog_pkg::MAP_WIDTH));
    assign row_ok = div_y.neg ? (div_y.quot == '0)
                              : (div_y.quot < pcog_pkg::QUOT_W'(pcog_pkg::MAP_HEIGHT));
    assign col    = div_x.neg ? '0 : div_x.quot[pcog_pkg::COL_W-1:0];
    assign row    = div_y.neg ? '0 : div_y.quot[pcog_pkg::ROW_W-1:0];

    assign cell_word = pcog_pkg::WORD_AW'(res_cell_reg >> pcog_pkg::BIT_W);
    assign cell_bit  = pcog_pkg::BIT_W'(res_cell_reg);

    // Bitmap storage
    pcog_ram #(
        .DEPTH (pcog_pkg::GRID_WORDS),
        .WIDTH (pcog_pkg::DATA_W),
        .AW    (pcog_pkg::WORD_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == pcog_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == pcog_pkg::S_RESP) && (!out_valid_reg || out_ready);

    // Sequencer: next state, RAM port and result fields
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_cmd_next    = clr_cmd_reg;
        res_status_next = res_status_reg;
        res_cell_next   = res_cell_reg;
        res_word_next   = res_word_reg;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = cell_word;
        ram_wdata       = '0;

        unique case (state_reg)
            pcog_pkg::S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == pcog_pkg::WORD_AW'(pcog_pkg::GRID_WORDS - 1))
                begin
                    state_next   = clr_cmd_reg ? pcog_pkg::S_RESP : pcog_pkg::S_IDLE;
                    clr_cmd_next = 1'b0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            pcog_pkg::S_IDLE:
            begin
                ram_addr = pcog_pkg::WORD_AW'(word_index);
                if (accept)
                begin
                    res_status_next = pcog_pkg::STAT_DONE;
                    res_cell_next   = '0;
                    res_word_next   = '0;
                    unique case (pcog_pkg::cmd_t'(command))
                        pcog_pkg::CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = pcog_pkg::S_CLEAR;
                        end
                        pcog_pkg::CMD_POINT:
                        begin
                            if (filtered)
                            begin
                                res_status_next = pcog_pkg::STAT_FILTERED;
                                state_next      = pcog_pkg::S_RESP;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = pcog_pkg::S_DIV;
                            end
                        end
                        pcog_pkg::CMD_READ:
                        begin
                            if (32'(word_index) < 32'(pcog_pkg::GRID_WORDS))
                            begin
                                state_next = pcog_pkg::S_RDATA;
                            end
                            else
                            begin
                                state_next = pcog_pkg::S_RESP;
                            end
                        end
                        pcog_pkg::CMD_NOP:
                        begin
                            state_next = pcog_pkg::S_RESP;
                        end
                        default: state_next = pcog_pkg::S_RESP;
                    endcase
                end
            end

            pcog_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    if (col_ok && row_ok)
                    begin
                        res_status_next = pcog_pkg::STAT_MARKED;
                        res_cell_next   = pcog_pkg::CIDX_W'(row)
                                        * pcog_pkg::CIDX_W'(pcog_pkg::MAP_WIDTH)
                                        + pcog_pkg::CIDX_W'(col);
                        state_next      = pcog_pkg::S_MREAD;
                    end
                    else
                    begin
                        res_status_next = pcog_pkg::STAT_OUTSIDE;
                        state_next      = pcog_pkg::S_RESP;
                    end
                end
            end

            pcog_pkg::S_MREAD:
            begin
                state_next = pcog_pkg::S_MMOD;
            end

            pcog_pkg::S_MMOD:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | (pcog_pkg::DATA_W'(1) << cell_bit);
                state_next = pcog_pkg::S_RESP;
            end

            pcog_pkg::S_RDATA:
            begin
                res_word_next = ram_rdata;
                state_next    = pcog_pkg::S_RESP;
            end

            pcog_pkg::S_RESP:
            begin
                if (out_load)
                begin
                    state_next = pcog_pkg::S_IDLE;
                end
            end

            default: state_next = pcog_pkg::S_IDLE;
        endcase
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pcog_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    // Result fields of the command in flight
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_cell_reg   <= res_cell_next;
        res_word_reg   <= res_word_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_cell_reg   <= pcog_pkg::CELL_W'(res_cell_reg);
            out_word_reg   <= res_word_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign cell_index     = out_cell_reg;
    assign occupancy_word = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcog_checker.sv =====
// Port-level checks for the occupancy grid, bound to the top level.
`default_nettype none

module pcog_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic        [pcog_pkg::STAT_W-1:0]   status,
    input wire logic        [pcog_pkg::CELL_W-1:0]   cell_index,
    input wire logic        [pcog_pkg::DATA_W-1:0]   occupancy_word,
    input wire logic                                 pready
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(cell_index) && $stable(occupancy_word))
        else $error("result beat changed while stalled");

    // Only one command in flight: ready drops after every accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while another is in flight");

    // Only a read carries a bitmap word
    a_word_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pcog_pkg::STAT_DONE) |-> occupancy_word == '0)
        else $error("nonzero word on a non-read result");

    // Cell index only for a marked cell
    a_cell_marked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pcog_pkg::STAT_MARKED) |-> cell_index == '0)
        else $error("cell index on an unmarked result");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind point_cloud_occupancy_grid pcog_checker u_pcog_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .cell_index     (cell_index),
    .occupancy_word (occupancy_word),
    .pready         (pready)
);

`default_nettype wire
